/* hw/rtl/websocket_frame_decoder_macros.svh */
// Assertion helpers for the frame decoder.
// Each expands to a labeled concurrent assertion on clk, quiet during rst.
`ifndef WEBSOCKET_FRAME_DECODER_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_MACROS_SVH

// Same-cycle implication.
`define WSFD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSFD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OPCODE  = 2'd1;
  localparam logic [1:0] ERR_CONTROL = 2'd2;
  localparam logic [1:0] ERR_SIZE    = 2'd3;

  // Defined opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Header constants
  localparam logic [6:0]  LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0]  LEN_CODE_EXT64 = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN   = 64'd125;
  localparam logic [3:0]  EXT16_BYTES    = 4'd2;
  localparam logic [3:0]  EXT64_BYTES    = 4'd8;
  localparam logic [3:0]  KEY_BYTES      = 4'd4;

  localparam logic [31:0] SIZE_LIMIT_RESET    = 32'd65536;
  localparam int          QUEUE_DEPTH_DEFAULT = 2;

  // One classified byte handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [63:0] length;
    logic [1:0]  err;
    logic        fin;
    logic [3:0]  opcode;
    logic        mask;
    logic [31:0] key;
  } entry_t;

  typedef struct packed {
    logic push;
    logic halted;
  } fstat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic opcode_defined(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

/* hw/rtl/wsfd_if.sv */
// ----------------------------------------------------------------------------
// wsfd_if
// Valid/ready channels of the frame decoder: byte stream in, results out.
// ----------------------------------------------------------------------------
interface wsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        final_fragment;
  logic [3:0]  frame_opcode;
  logic [63:0] frame_length;
  logic [1:0]  error_code;
  logic        end_of_frame;

  modport source (output valid, output result_kind, output payload_byte,
                  output final_fragment, output frame_opcode, output frame_length,
                  output error_code, output end_of_frame, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input final_fragment, input frame_opcode, input frame_length,
                  input error_code, input end_of_frame, output ready);
endinterface

/* hw/rtl/websocket_frame_decoder.sv */
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// WebSocket (RFC 6455) receive-side frame parser with payload unmasking.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                                     | Transfer
//  ---------+-----+---------------------------------------------+----------------
//  stream   | in  | stream_byte                                 | valid && ready
//  result   | out | kind, byte, fin, opcode, length, err, eof   | valid && ready
//  cfg      | in  | cfg_wdata (payload size limit)              | cfg_we
//
//  One byte per clock in and one result per clock out in steady state.
//  A byte is written into the queue and from there into the result register;
//  header bytes other than the last give no result.
//  The result queue (QUEUE_DEPTH entries) lets the parser run on while the
//  output stalls; stream.ready drops only when that queue is full.
//  Synchronous reset; after an error result the parser stays halted until rst.
// ----------------------------------------------------------------------------
`include "websocket_frame_decoder_macros.svh"

module websocket_frame_decoder #(
  parameter int QUEUE_DEPTH = wsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  wsfd_byte_if.sink     stream,
  wsfd_result_if.source result
);

  wsfd_pkg::entry_t entry;
  wsfd_pkg::entry_t head;
  wsfd_pkg::fstat_t fstat;
  wsfd_pkg::qstat_t qstat;
  logic             pop;

  wsfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stream    (stream),
    .qstat     (qstat),
    .fstat     (fstat),
    .entry     (entry)
  );

  wsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fstat.push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  wsfd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .result (result)
  );

  // Checks
  `WSFD_ASSERT_NOW(a_push_has_room, fstat.push, !qstat.full, "queue push while full")
  `WSFD_ASSERT_NEXT(a_error_halts, fstat.push && (entry.kind == wsfd_pkg::KIND_ERROR), fstat.halted, "no halt after error")
  `WSFD_ASSERT_NEXT(a_halt_sticky, fstat.halted, fstat.halted, "halt released without reset")
  `WSFD_ASSERT_NOW(a_error_fields, result.valid && (result.result_kind == wsfd_pkg::KIND_ERROR), !result.end_of_frame && (result.error_code != wsfd_pkg::ERR_NONE), "malformed error result")

endmodule

/* hw/rtl/wsfd_front.sv */
// ----------------------------------------------------------------------------
// wsfd_front
// Header parser: takes stream bytes, runs the header checks and queues one
// entry per frame start, error or payload byte.
// ----------------------------------------------------------------------------
module wsfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  wsfd_byte_if.sink         stream,
  input  wsfd_pkg::qstat_t  qstat,
  output wsfd_pkg::fstat_t  fstat,
  output wsfd_pkg::entry_t  entry
);

  typedef enum logic [2:0] {
    PH_BYTE0, PH_BYTE1, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_HALT
  } phase_t;

  phase_t      phase;
  logic [3:0]  hdr_count;
  logic        fin_flag;
  logic [3:0]  opcode_reg;
  logic        mask_present;
  logic [63:0] length_accum;
  logic [31:0] masking_key;
  logic [63:0] bytes_remaining;
  logic [31:0] size_limit;

  logic        accept;
  logic [7:0]  b;
  logic        finish;
  logic [63:0] fin_len;
  logic [63:0] ext_len;
  logic [31:0] key_shift;
  logic [1:0]  err;
  logic        data_last;

  assign b            = stream.stream_byte;
  assign stream.ready = !qstat.full;
  assign accept       = stream.valid && stream.ready;
  assign ext_len      = {length_accum[55:0], b};
  assign key_shift    = {masking_key[23:0], b};
  assign data_last    = (bytes_remaining == 64'd1);

  // Header completion and its length
  always_comb begin
    finish  = 1'b0;
    fin_len = length_accum;
    case (phase)
      PH_BYTE1: begin
        fin_len = {57'd0, b[6:0]};
        finish  = (b[6:0] != wsfd_pkg::LEN_CODE_EXT16) &&
                  (b[6:0] != wsfd_pkg::LEN_CODE_EXT64) && !b[7];
      end
      PH_EXTLEN: begin
        fin_len = ext_len;
        finish  = (hdr_count == 4'd1) && !mask_present;
      end
      PH_KEY: begin
        finish  = (hdr_count == 4'd1);
      end
      default: begin
        finish  = 1'b0;
      end
    endcase
  end

  // Header checks, in priority order
  always_comb begin
    if (!wsfd_pkg::opcode_defined(opcode_reg)) begin
      err = wsfd_pkg::ERR_OPCODE;
    end else if (opcode_reg[3] && (!fin_flag || fin_len > wsfd_pkg::CTRL_MAX_LEN)) begin
      err = wsfd_pkg::ERR_CONTROL;
    end else if (fin_len > {32'd0, size_limit}) begin
      err = wsfd_pkg::ERR_SIZE;
    end else begin
      err = wsfd_pkg::ERR_NONE;
    end
  end

  // Queue entry
  always_comb begin
    entry.data   = b;
    entry.fin    = fin_flag;
    entry.opcode = opcode_reg;
    entry.mask   = (phase == PH_KEY);
    entry.key    = key_shift;
    entry.length = fin_len;
    entry.err    = err;
    if (phase == PH_PAYLOAD) begin
      entry.kind = wsfd_pkg::KIND_DATA;
      entry.last = data_last;
    end else if (err != wsfd_pkg::ERR_NONE) begin
      entry.kind = wsfd_pkg::KIND_ERROR;
      entry.last = 1'b0;
    end else begin
      entry.kind = wsfd_pkg::KIND_START;
      entry.last = (fin_len == 64'd0);
    end
  end

  assign fstat.push   = accept && (finish || (phase == PH_PAYLOAD));
  assign fstat.halted = (phase == PH_HALT);

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= wsfd_pkg::SIZE_LIMIT_RESET;
    end else if (cfg_we) begin
      size_limit <= cfg_wdata;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_BYTE0;
      hdr_count       <= '0;
      fin_flag        <= 1'b0;
      opcode_reg      <= '0;
      mask_present    <= 1'b0;
      length_accum    <= '0;
      masking_key     <= '0;
      bytes_remaining <= '0;
    end else if (accept) begin
      case (phase)
        PH_BYTE0: begin
          fin_flag   <= b[7];
          opcode_reg <= b[3:0];
          phase      <= PH_BYTE1;
        end
        PH_BYTE1: begin
          mask_present <= b[7];
          if (b[6:0] == wsfd_pkg::LEN_CODE_EXT16) begin
            length_accum <= '0;
            hdr_count    <= wsfd_pkg::EXT16_BYTES;
            phase        <= PH_EXTLEN;
          end else if (b[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
            length_accum <= '0;
            hdr_count    <= wsfd_pkg::EXT64_BYTES;
            phase        <= PH_EXTLEN;
          end else if (b[7]) begin
            length_accum <= fin_len;
            hdr_count    <= wsfd_pkg::KEY_BYTES;
            masking_key  <= '0;
            phase        <= PH_KEY;
          end else begin
            length_accum <= fin_len;
          end
        end
        PH_EXTLEN: begin
          length_accum <= ext_len;
          if (hdr_count == 4'd1 && mask_present) begin
            hdr_count   <= wsfd_pkg::KEY_BYTES;
            masking_key <= '0;
            phase       <= PH_KEY;
          end else begin
            hdr_count   <= hdr_count - 4'd1;
          end
        end
        PH_KEY: begin
          masking_key <= key_shift;
          hdr_count   <= hdr_count - 4'd1;
        end
        PH_PAYLOAD: begin
          bytes_remaining <= bytes_remaining - 64'd1;
          if (data_last) begin
            phase <= PH_BYTE0;
          end
        end
        default: begin
          phase <= PH_HALT;
        end
      endcase
      // Header done: start payload, go back for a new header, or halt
      if (finish) begin
        bytes_remaining <= fin_len;
        if (err != wsfd_pkg::ERR_NONE) begin
          phase <= PH_HALT;
        end else if (fin_len == 64'd0) begin
          phase <= PH_BYTE0;
        end else begin
          phase <= PH_PAYLOAD;
        end
      end
    end
  end

endmodule

/* hw/rtl/wsfd_queue.sv */
// ----------------------------------------------------------------------------
// wsfd_queue
// Small register FIFO between the parser and the result stage.
// ----------------------------------------------------------------------------
module wsfd_queue #(
  parameter int DEPTH = wsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsfd_pkg::entry_t  wr_entry,
  input  logic              pop,
  output wsfd_pkg::entry_t  head,
  output wsfd_pkg::qstat_t  qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsfd_pkg::entry_t   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/wsfd_back.sv */
// ----------------------------------------------------------------------------
// wsfd_back
// Result stage: unmasks payload bytes with the cycling key and holds each
// result in an output register until its transfer.
// ----------------------------------------------------------------------------
module wsfd_back (
  input  logic              clk,
  input  logic              rst,
  input  wsfd_pkg::entry_t  head,
  input  wsfd_pkg::qstat_t  qstat,
  output logic              pop,
  wsfd_result_if.source     result
);

  logic [31:0] key;
  logic        mask;
  logic [1:0]  key_pos;
  logic [7:0]  key_byte;

  assign pop = !qstat.empty && (!result.valid || result.ready);

  // Key byte for the current position
  always_comb begin
    case (key_pos)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  // Output register and frame key state
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      key_pos      <= '0;
      mask         <= 1'b0;
      key          <= '0;
    end else begin
      if (pop) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (pop) begin
        if (head.kind == wsfd_pkg::KIND_START) begin
          key     <= head.key;
          mask    <= head.mask;
          key_pos <= '0;
        end else if (head.kind == wsfd_pkg::KIND_DATA) begin
          key_pos <= key_pos + 2'd1;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      result.result_kind    <= head.kind;
      result.final_fragment <= head.fin;
      result.frame_opcode   <= head.opcode;
      result.end_of_frame   <= head.last;
      if (head.kind == wsfd_pkg::KIND_DATA) begin
        result.payload_byte <= head.data ^ (mask ? key_byte : 8'd0);
        result.frame_length <= '0;
        result.error_code   <= wsfd_pkg::ERR_NONE;
      end else begin
        result.payload_byte <= '0;
        result.frame_length <= head.length;
        result.error_code   <= head.err;
      end
    end
  end

endmodule

/* tb/websocket_frame_decoder_tb.sv */
// ----------------------------------------------------------------------------
// websocket_frame_decoder_tb
// Feeds framed byte streams into the WebSocket frame decoder and checks every
// result against an in-bench frame parser: headers of every length form,
// masked and plain payloads, all defined opcodes and several size limits.
// The run ends with one bad header, whose error halts the parser for good.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_tb;

  // Length encodings of a header
  localparam int ENC_SHORT = 0;
  localparam int ENC_EXT16 = 1;
  localparam int ENC_EXT64 = 2;

  // Bad header flavors for the closing frame
  localparam int BAD_OPCODE  = 1;
  localparam int BAD_CONTROL = 2;
  localparam int BAD_SIZE    = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        fin;
    logic [3:0]  opcode;
    logic [63:0] length;
    logic [1:0]  err;
    logic        eof;
  } frame_result_t;

  typedef enum logic [2:0] {
    RX_FIRST, RX_LEN, RX_EXTLEN, RX_KEY, RX_PAYLOAD, RX_HALTED
  } rx_phase_t;

  // --------------------------------------------------------------------------
  // Frame parser and store of expected results
  // --------------------------------------------------------------------------
  class frame_tracker_t;
    rx_phase_t     phase;
    logic [3:0]    hdr_left;
    logic          fin;
    logic [3:0]    op;
    logic          masked;
    logic [63:0]   len;
    logic [31:0]   key;
    logic [63:0]   remaining;
    logic [1:0]    kpos;
    logic [31:0]   limit;
    frame_result_t pending[$];
    int            errors;
    int            seen;

    function new();
      phase     = RX_FIRST;
      hdr_left  = '0;
      fin       = 1'b0;
      op        = '0;
      masked    = 1'b0;
      len       = '0;
      key       = '0;
      remaining = '0;
      kpos      = '0;
      limit     = wsfd_pkg::SIZE_LIMIT_RESET;
      errors    = 0;
      seen      = 0;
    endfunction

    function void set_limit(logic [31:0] v);
      limit = v;
    endfunction

    function bit known_op(logic [3:0] o);
      return o == wsfd_pkg::OP_CONT || o == wsfd_pkg::OP_TEXT ||
             o == wsfd_pkg::OP_BIN || o == wsfd_pkg::OP_CLOSE ||
             o == wsfd_pkg::OP_PING || o == wsfd_pkg::OP_PONG;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] data, logic [63:0] length,
                       logic [1:0] err, logic eof);
      frame_result_t r;
      r.kind   = kind;
      r.data   = data;
      r.fin    = fin;
      r.opcode = op;
      r.length = length;
      r.err    = err;
      r.eof    = eof;
      pending  = {pending, r};
    endfunction

    // Header done: checks in order opcode, control rules, size limit
    function void close_header();
      logic [1:0] err;
      err = wsfd_pkg::ERR_NONE;
      if (!known_op(op))
        err = wsfd_pkg::ERR_OPCODE;
      else if (op[3] && (!fin || len > wsfd_pkg::CTRL_MAX_LEN))
        err = wsfd_pkg::ERR_CONTROL;
      else if (len > {32'd0, limit})
        err = wsfd_pkg::ERR_SIZE;
      if (err != wsfd_pkg::ERR_NONE) begin
        phase = RX_HALTED;
        push(wsfd_pkg::KIND_ERROR, 8'h00, len, err, 1'b0);
      end else begin
        kpos      = '0;
        remaining = len;
        if (len == 0) begin
          phase = RX_FIRST;
          push(wsfd_pkg::KIND_START, 8'h00, 64'd0, wsfd_pkg::ERR_NONE, 1'b1);
        end else begin
          phase = RX_PAYLOAD;
          push(wsfd_pkg::KIND_START, 8'h00, len, wsfd_pkg::ERR_NONE, 1'b0);
        end
      end
    endfunction

    function void after_len();
      if (masked) begin
        phase    = RX_KEY;
        hdr_left = wsfd_pkg::KEY_BYTES;
        key      = '0;
      end else begin
        close_header();
      end
    endfunction

    // One accepted stream byte
    function void take_byte(logic [7:0] b);
      logic [7:0] kb;
      case (phase)
        RX_FIRST: begin
          fin   = b[7];
          op    = b[3:0];
          phase = RX_LEN;
        end
        RX_LEN: begin
          masked = b[7];
          len    = '0;
          if (b[6:0] == wsfd_pkg::LEN_CODE_EXT16) begin
            phase    = RX_EXTLEN;
            hdr_left = wsfd_pkg::EXT16_BYTES;
          end else if (b[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
            phase    = RX_EXTLEN;
            hdr_left = wsfd_pkg::EXT64_BYTES;
          end else begin
            len = {57'd0, b[6:0]};
            after_len();
          end
        end
        RX_EXTLEN: begin
          len      = {len[55:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) after_len();
        end
        RX_KEY: begin
          key      = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) close_header();
        end
        RX_PAYLOAD: begin
          kb        = masked ? 8'(key >> (24 - 8 * kpos)) : 8'h00;
          kpos      = kpos + 2'd1;
          remaining = remaining - 64'd1;
          if (remaining == 0) begin
            phase = RX_FIRST;
            push(wsfd_pkg::KIND_DATA, b ^ kb, 64'd0, wsfd_pkg::ERR_NONE, 1'b1);
          end else begin
            push(wsfd_pkg::KIND_DATA, b ^ kb, 64'd0, wsfd_pkg::ERR_NONE, 1'b0);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one result transfer with the oldest expectation
    task match_result(frame_result_t got);
      frame_result_t exp;
      seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d: unexpected, kind %0d", seen, got.kind));
      end else begin
        exp = pending.pop_front();
        if (got.kind !== exp.kind)
          report($sformatf("result %0d: kind %0d, want %0d", seen, got.kind, exp.kind));
        if (got.data !== exp.data)
          report($sformatf("result %0d: byte %h, want %h", seen, got.data, exp.data));
        if (got.fin !== exp.fin)
          report($sformatf("result %0d: fin %b, want %b", seen, got.fin, exp.fin));
        if (got.opcode !== exp.opcode)
          report($sformatf("result %0d: opcode %h, want %h", seen, got.opcode, exp.opcode));
        if (got.length !== exp.length)
          report($sformatf("result %0d: length %h, want %h", seen, got.length, exp.length));
        if (got.err !== exp.err)
          report($sformatf("result %0d: error %0d, want %0d", seen, got.err, exp.err));
        if (got.eof !== exp.eof)
          report($sformatf("result %0d: eof %b, want %b", seen, got.eof, exp.eof));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, block and channels
  // --------------------------------------------------------------------------
  logic           clk;
  logic           rst;
  logic           cfg_we;
  logic [31:0]    cfg_wdata;
  bit             no_idle;
  int             bytes_sent;
  frame_tracker_t sb;

  wsfd_byte_if   stream_ch ();
  wsfd_result_if result_ch ();

  websocket_frame_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stream    (stream_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #4000000;
    $display("websocket_frame_decoder_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, check each transfer
  // --------------------------------------------------------------------------
  initial begin
    frame_result_t got;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.kind   = result_ch.result_kind;
        got.data   = result_ch.payload_byte;
        got.fin    = result_ch.final_fragment;
        got.opcode = result_ch.frame_opcode;
        got.length = result_ch.frame_length;
        got.err    = result_ch.error_code;
        got.eof    = result_ch.end_of_frame;
        sb.match_result(got);
      end
      result_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 14);
    end
  end

  // --------------------------------------------------------------------------
  // Stream side tasks
  // --------------------------------------------------------------------------
  // Offer one byte, with an occasional gap first, and wait for its transfer.
  task send_byte(input logic [7:0] b);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 5) begin
      stream_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= b;
    do @(posedge clk); while (!stream_ch.ready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task release_stream();
    stream_ch.valid <= 1'b0;
  endtask

  // Wait for all expected results, then a few cycles more
  task drain();
    int n;
    n = 0;
    while (sb.pending.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  task write_limit(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // Header in the chosen length form, key if masked, then random payload if with_payload is set
  task send_frame(input logic fin, input logic [3:0] op, input logic masked,
                  input logic [63:0] len, input int enc, input bit with_payload);
    logic [6:0]  code;
    logic [31:0] key;
    logic [63:0] i;
    int          r;
    if (enc == ENC_EXT16)
      code = wsfd_pkg::LEN_CODE_EXT16;
    else if (enc == ENC_EXT64)
      code = wsfd_pkg::LEN_CODE_EXT64;
    else if (len <= 64'd125)
      code = len[6:0];
    else if (len <= 64'd65535)
      code = wsfd_pkg::LEN_CODE_EXT16;
    else
      code = wsfd_pkg::LEN_CODE_EXT64;
    r = $urandom_range(0, 9);
    key = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    // reserved bits are random; the parser ignores them
    send_byte({fin, 3'($urandom_range(0, 7)), op});
    send_byte({masked, code});
    if (code == wsfd_pkg::LEN_CODE_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (code == wsfd_pkg::LEN_CODE_EXT64) begin
      for (r = 7; r >= 0; r--) send_byte(len[8 * r +: 8]);
    end
    if (masked)
      for (r = 3; r >= 0; r--) send_byte(key[8 * r +: 8]);
    if (with_payload)
      for (i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // Well-formed frame that fits the given limit
  task rand_frame(input logic [31:0] lim);
    logic [3:0]  op;
    logic        fin;
    logic        masked;
    logic [63:0] len;
    logic [63:0] cap;
    int          r;
    int          enc;
    case ($urandom_range(0, 5))
      0: op = wsfd_pkg::OP_CONT;
      1: op = wsfd_pkg::OP_TEXT;
      2: op = wsfd_pkg::OP_BIN;
      3: op = wsfd_pkg::OP_CLOSE;
      4: op = wsfd_pkg::OP_PING;
      default: op = wsfd_pkg::OP_PONG;
    endcase
    masked = 1'($urandom_range(0, 1));
    fin    = op[3] ? 1'b1 : 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 10)
      len = 64'd0;
    else if (r < 75)
      len = 64'($urandom_range(1, 16));
    else if (r < 92)
      len = 64'($urandom_range(17, 125));
    else
      len = 64'($urandom_range(126, 400));
    cap = {32'd0, lim};
    if (op[3] && cap > wsfd_pkg::CTRL_MAX_LEN) cap = wsfd_pkg::CTRL_MAX_LEN;
    if (len > cap) len = cap;
    r = $urandom_range(0, 99);
    enc = (r < 12) ? ENC_EXT16 : (r < 20) ? ENC_EXT64 : ENC_SHORT;
    send_frame(fin, op, masked, len, enc, 1'b1);
  endtask

  task rand_frames_until(input int target);
    while (bytes_sent < target) rand_frame(sb.limit);
  endtask

  // One header that fails a check; the parser halts after it
  task send_bad_frame(input logic [31:0] lim);
    logic [3:0]  op;
    logic        fin;
    logic [63:0] len;
    int          enc;
    fin = 1'($urandom_range(0, 1));
    enc = ENC_SHORT;
    case ($urandom_range(BAD_OPCODE, BAD_SIZE))
      BAD_OPCODE: begin
        op = 4'($urandom_range(3, 15));
        if (op == wsfd_pkg::OP_CLOSE || op == wsfd_pkg::OP_PING || op == wsfd_pkg::OP_PONG)
          op = 4'($urandom_range(3, 7));
        len = 64'($urandom_range(0, 20));
      end
      BAD_CONTROL: begin
        op = 4'($urandom_range(wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PONG));
        if ($urandom_range(0, 1)) begin
          fin = 1'b0;
          len = 64'($urandom_range(0, 125));
        end else begin
          fin = 1'b1;
          len = 64'($urandom_range(126, 300));
        end
      end
      default: begin
        op = 4'($urandom_range(wsfd_pkg::OP_CONT, wsfd_pkg::OP_BIN));
        if ($urandom_range(0, 1)) begin
          // top length bit set
          len = {1'b1, 31'($urandom), 32'($urandom)};
          enc = ENC_EXT64;
        end else begin
          len = {32'd0, lim} + 64'd1 + $urandom_range(0, 40);
        end
      end
    endcase
    send_frame(fin, op, 1'($urandom_range(0, 1)), len, enc, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    sb                    = new();
    no_idle               = 1'b0;
    bytes_sent            = 0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    stream_ch.valid       = 1'b0;
    stream_ch.stream_byte = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: payload byte extremes unmasked, zero-length masked ping,
    // 16-bit length form, empty close and pong
    send_byte({1'b1, 3'b000, wsfd_pkg::OP_TEXT});
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b1, wsfd_pkg::OP_PING, 1'b1, 64'd0, ENC_SHORT, 1'b1);
    send_frame(1'b0, wsfd_pkg::OP_BIN, 1'b1, 64'd1, ENC_EXT16, 1'b1);
    send_frame(1'b1, wsfd_pkg::OP_CLOSE, 1'b0, 64'd0, ENC_SHORT, 1'b1);
    send_frame(1'b1, wsfd_pkg::OP_PONG, 1'b0, 64'd0, ENC_SHORT, 1'b1);

    // Random frames at the reset limit
    rand_frames_until(330);
    release_stream();
    drain();

    // Widest limit, no idling on either side
    write_limit(32'hFFFF_FFFF);
    no_idle = 1'b1;
    rand_frames_until(700);
    release_stream();
    drain();
    no_idle = 1'b0;

    // Zero limit: only empty frames pass
    write_limit(32'd0);
    rand_frames_until(800);
    release_stream();
    drain();

    // A small limit, longer frames cut to it; then a random limit
    write_limit($urandom_range(126, 600));
    rand_frames_until(1200);
    release_stream();
    drain();

    write_limit($urandom);
    rand_frames_until(1750);
    release_stream();
    drain();

    // Closing bad header, then bytes the halted parser must ignore
    r = $urandom_range(0, 3);
    write_limit((r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 500));
    send_bad_frame(sb.limit);
    repeat (4) send_byte(8'($urandom));
    release_stream();
    drain();

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected results never came", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("websocket_frame_decoder_tb: done, clean");
    end else begin
      $display("websocket_frame_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
